[rtl/core/button_auto_repeat_tracker_top_macros.svh]
// Assertion macros shared by the button auto-repeat tracker RTL.
`ifndef BUTTON_AUTO_REPEAT_TRACKER_TOP_MACROS_SVH
`define BUTTON_AUTO_REPEAT_TRACKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge outside reset.
`define BART_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a condition implies another in the same cycle.
`define BART_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define BART_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BART_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define BART_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BART_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/bart_pkg.sv]
// Types, constants and the countdown update rule of the button auto-repeat tracker.
`default_nettype none

package bart_pkg;

   localparam int PLAYERS_DEFAULT = 8;
   localparam int BUTTONS_DEFAULT = 8;
   localparam int PLAYERS_MAX     = 8;
   localparam int BUTTONS_MAX     = 8;

   localparam int CD_W    = 9;
   localparam int CFG_W   = 8;
   localparam int INDEX_W = 2;
   localparam int FRAME_W = 32;
   localparam int MASK_W  = PLAYERS_MAX * BUTTONS_MAX;

   // Register indexes of the configuration port
   localparam logic [INDEX_W-1:0] CSR_FIRST_DELAY = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_INTERVAL    = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_SWAP        = 2'd2;

   localparam logic [CFG_W-1:0] REPEAT_OFF       = 8'hFF;
   localparam logic [CD_W-1:0]  FIRST_DEFAULT    = 9'd16;
   localparam logic [CD_W-1:0]  INTERVAL_DEFAULT = 9'd5;
   localparam logic [CD_W-1:0]  CD_DISABLED      = 9'h1FF;
   localparam logic [CD_W-1:0]  CD_ZERO          = 9'd0;
   localparam logic [CD_W-1:0]  CD_ONE           = 9'd1;

   localparam logic [2:0] BUTTON_A = 3'd4;
   localparam logic [2:0] BUTTON_B = 3'd5;

   typedef struct packed {
      logic [CFG_W-1:0] first_delay;
      logic [CFG_W-1:0] interval;
   } cfg_type;

   // One button: held bit and two's complement countdown (-1 .. 255)
   typedef struct packed {
      logic            held;
      logic [CD_W-1:0] cd;
   } cell_type;

   typedef struct packed {
      logic shift;
      logic hit;
      logic down;
   } cell_ctrl_type;

   function automatic cell_type bart_next(cell_type c, cfg_type cfg);
      cell_type n;
      n = c;
      if (c.held && c.cd == CD_ZERO) begin
         if (cfg.first_delay == '0) begin
            n.cd = FIRST_DEFAULT;
         end else if (cfg.first_delay == REPEAT_OFF) begin
            n.cd = CD_DISABLED;
         end else begin
            n.cd = {1'b0, cfg.first_delay};
         end
      end else if (c.held && c.cd == CD_ONE) begin
         n.cd = (cfg.interval == '0) ? INTERVAL_DEFAULT : {1'b0, cfg.interval};
      end else if (!c.cd[CD_W-1] && c.cd != CD_ZERO) begin
         n.cd = c.cd - CD_ONE;
      end
      return n;
   endfunction

   function automatic logic bart_pressed(cell_type c);
      return c.held && (c.cd == CD_ZERO || c.cd == CD_ONE);
   endfunction

endpackage

`default_nettype wire

[rtl/core/button_auto_repeat_tracker_top.sv]
// Top level of the button auto-repeat tracker: control, cell ring and result register.
//
// Usage:
//  - req channel: one request per key event or frame tick. req_tuser[0] is the
//    action (0 key event, 1 frame tick); req_tdata carries player, button, down.
//  - rsp channel: one result per request: held mask, just-pressed mask and
//    frame count, 160 bits in rsp_tdata.
//  - csr port: write first_repeat_delay, repeat_interval and swap_confirm_buttons
//    while no request is in flight.
//  - Order: a key event passes the DONE state and then the result register;
//    a frame tick first walks the ring of cells once through the single update
//    point, one counter a cycle, then passes DONE and the result register.
//  - Requests: one request at a time; a new request is taken only once the
//    last one has left the DONE state and the block is idle again.
//  - Reset: clears held bits, countdowns, frame count, state, csr registers
//    and result valid (not result data); no request is taken in reset.
//  - Stall: a finished result waits in the output register; a new request is
//    taken meanwhile, and its result waits until the register frees up.
`default_nettype none
`include "button_auto_repeat_tracker_top_macros.svh"

module button_auto_repeat_tracker_top #(
   parameter int PLAYERS = bart_pkg::PLAYERS_DEFAULT,
   parameter int BUTTONS = bart_pkg::BUTTONS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   // request channel
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [7:0]                    req_tdata,  // player[2:0], button[5:3], down[6]
   input  wire  [0:0]                    req_tuser,  // action[0]
   // result channel
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [159:0]                  rsp_tdata,  // held_mask[63:0],
                                                     // pressed_now_mask[127:64],
                                                     // frame_count[159:128]
   // configuration
   input  wire                           csr_wr_en,
   input  wire  [bart_pkg::INDEX_W-1:0]  csr_index,
   input  wire  [bart_pkg::CFG_W-1:0]    csr_wdata
);
   import bart_pkg::*;

   localparam int CELLS = PLAYERS * BUTTONS;
   localparam int CNT_W = $clog2(CELLS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   cfg_type            cfg_ff;
   logic               swap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [159:0]       rsp_data_ff, rsp_data_in;

   logic               req_fire, fire_tick, fire_key, key_ok, slot_free, load_rsp;
   logic [2:0]         req_player, req_button, button_eff;
   logic               req_down;
   cell_type           cell_q   [CELLS];
   cell_type           chain_in [CELLS];
   logic [MASK_W-1:0]  held_vec, pressed_vec;

   // Unpack the request
   assign req_player = req_tdata[2:0];
   assign req_button = req_tdata[5:3];
   assign req_down   = req_tdata[6];

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign fire_tick  = req_fire && req_tuser[0];
   assign fire_key   = req_fire && !req_tuser[0];

   // Exchange the confirm buttons when enabled
   always_comb begin
      button_eff = req_button;
      if (swap_ff) begin
         if (req_button == BUTTON_A) begin
            button_eff = BUTTON_B;
         end else if (req_button == BUTTON_B) begin
            button_eff = BUTTON_A;
         end
      end
   end

   // Drop key events that fall outside the configured grid
   assign key_ok = fire_key && ({1'b0, req_player} < 4'(PLAYERS))
                            && ({1'b0, button_eff} < 4'(BUTTONS));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         swap_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRST_DELAY: cfg_ff.first_delay <= csr_wdata;
            CSR_INTERVAL:    cfg_ff.interval    <= csr_wdata;
            CSR_SWAP:        swap_ff            <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // Ring of cells: the slot leaving the last cell passes the update rule
   // on its way back into cell 0, so one full rotation updates every counter.
   assign chain_in[0] = bart_next(cell_q[CELLS-1], cfg_ff);

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      localparam int P = k / BUTTONS;
      localparam int B = k % BUTTONS;
      cell_ctrl_type ctrl;

      if (k > 0) begin : g_link
         assign chain_in[k] = cell_q[k-1];
      end

      assign ctrl.shift = (state_ff == ST_WALK);
      assign ctrl.hit   = key_ok && (req_player == 3'(P)) && (button_eff == 3'(B));
      assign ctrl.down  = req_down;

      bart_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .shift_in  (chain_in[k]),
         .state_out (cell_q[k])
      );
   end

   // Place each cell on its bit player*8+button; unused bits stay low
   for (genvar p = 0; p < PLAYERS_MAX; p++) begin : g_mask_p
      for (genvar b = 0; b < BUTTONS_MAX; b++) begin : g_mask_b
         if (p < PLAYERS && b < BUTTONS) begin : g_used
            assign held_vec[p*BUTTONS_MAX + b]    = cell_q[p*BUTTONS + b].held;
            assign pressed_vec[p*BUTTONS_MAX + b] = bart_pressed(cell_q[p*BUTTONS + b]);
         end else begin : g_unused
            assign held_vec[p*BUTTONS_MAX + b]    = 1'b0;
            assign pressed_vec[p*BUTTONS_MAX + b] = 1'b0;
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign load_rsp  = (state_ff == ST_DONE) && slot_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      frame_in = frame_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire_tick) begin
               state_in = ST_WALK;
               cnt_in   = '0;
               frame_in = frame_ff + FRAME_W'(1);
            end else if (fire_key) begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: hold until taken, load when the request completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {frame_ff, pressed_vec, held_vec};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BART_ASSERT_NEXT(a_tick_walks, clock, reset, fire_tick,
                     state_ff == ST_WALK && cnt_ff == '0, "tick did not start a walk")
   `BART_ASSERT_SAME(a_walk_bound, clock, reset, state_ff == ST_WALK,
                     cnt_ff < CNT_W'(CELLS), "walk counter overran the ring")
   `BART_ASSERT_NEXT(a_result_loaded, clock, reset, load_rsp,
                     rsp_valid_ff && state_ff == ST_IDLE, "result not presented")
   `BART_ASSERT_NEXT(a_frame_steady, clock, reset, !fire_tick,
                     $stable(frame_ff), "frame count moved without a tick")

endmodule

`default_nettype wire

[rtl/core/bart_cell.sv]
// One button slot of the tracker ring: held bit and repeat countdown.
`default_nettype none

module bart_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire bart_pkg::cell_ctrl_type ctrl,
   input  wire bart_pkg::cell_type   shift_in,
   output bart_pkg::cell_type        state_out
);
   import bart_pkg::*;

   cell_type slot_ff;
   cell_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.shift) begin
         slot_in = shift_in;
      end else if (ctrl.hit) begin
         slot_in.held = ctrl.down;
         slot_in.cd   = CD_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign state_out = slot_ff;

endmodule

`default_nettype wire
